@@ hdl/tpta_pkg.sv @@
// Shared types, constants and CORDIC table for the three point turn angle block.
`default_nettype none
package tpta_pkg;

  localparam int COORD_W           = 32;
  localparam int ANGLE_W           = 32;
  localparam int ACC_W             = 64;
  localparam int COORD_WIDTH_DEF   = 32;
  localparam int CORDIC_STAGES_DEF = 28;
  localparam int CORDIC_MAX        = 40;
  localparam int PREP_LAT          = 5;
  localparam int POST_LAT          = 9;
  localparam int NORM_TOP          = 56;
  localparam int RECIP_SH          = 33;
  localparam int ADDR_W            = 3;
  localparam int DATA_W            = 32;

  localparam logic [0:0]  REG_ANGLE_UNIT = 1'b0;
  localparam logic [31:0] DEG180_Q22     = 32'd754974720;

  typedef struct packed {
    logic                      kind;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by_coord;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } item_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic                      valid_res;
  } result_t;

  typedef struct packed {
    logic zero;
    logic dx_zero;
    logic dy_zero;
    logic dx_pos;
    logic dy_pos;
  } flags_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] x;
    logic signed [ACC_W-1:0] y;
    logic signed [ACC_W-1:0] acc;
  } vec_t;

  typedef struct packed {
    logic                    ok;
    logic signed [ACC_W-1:0] z;
  } lane_t;

  typedef struct packed {
    logic valid;
    logic kind;
  } ctrl_t;

  typedef logic signed [ACC_W-1:0] atan_tab_t [CORDIC_MAX];

  // shift-subtract divide, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem    = rem - {1'b0, d};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // truncated arctan series; q == 0 means the ratio is a shift by qsh
  function automatic logic [63:0] atan_series(input logic [63:0] p_in, input logic [63:0] q,
                                              input int unsigned qsh);
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] t;
    logic        neg;
    logic [63:0] k;
    p   = p_in;
    s   = '0;
    neg = 1'b0;
    k   = '0;
    for (int n = 0; n < 64; n++) begin
      if (p != '0) begin
        t   = udiv64(p, 2 * k + 64'd1);
        s   = neg ? s - t : s + t;
        neg = !neg;
        k   = k + 64'd1;
        if (q != '0) p = udiv64(p, q);
        else if (qsh < 64) p = p >> qsh;
        else p = '0;
      end
    end
    return s;
  endfunction

  function automatic logic [63:0] quarter_q60();
    logic [63:0] one;
    one = 64'd1 << 60;
    return 4 * atan_series(udiv64(one, 64'd5), 64'd25, 0)
           - atan_series(udiv64(one, 64'd239), 64'd57121, 0);
  endfunction

  function automatic atan_tab_t build_atan_tab();
    atan_tab_t tab;
    for (int i = 0; i < CORDIC_MAX; i++) begin
      if (i == 0) tab[i] = $signed(quarter_q60());
      else tab[i] = $signed(atan_series((64'd1 << 60) >> i, 64'd0, 2 * i));
    end
    return tab;
  endfunction

  localparam atan_tab_t   ATAN_TAB   = build_atan_tab();
  localparam logic [63:0] PI_U       = quarter_q60() << 2;
  localparam logic signed [ACC_W-1:0] PI_Q60      = $signed(PI_U);
  localparam logic signed [ACC_W-1:0] HALF_PI_Q60 = $signed(PI_U >> 1);
  localparam logic signed [ACC_W-1:0] TWO_PI_Q60  = $signed(PI_U << 1);
  localparam logic [63:0] PI30_W     = (PI_U + (64'd1 << 29)) >> 30;
  localparam logic [31:0] PI30       = PI30_W[31:0];
  localparam logic [31:0] PI30_HALF  = PI30 >> 1;
  localparam logic [63:0] RECIP_W    = udiv64({32'd0, DEG180_Q22} << RECIP_SH, PI30_W);
  localparam logic [30:0] DEG_RECIP  = RECIP_W[30:0];

endpackage
`default_nettype wire

@@ hdl/tpta_prep.sv @@
// Front end of one lane: difference, magnitude, normalize and half-plane fold.
`default_nettype none
module tpta_prep #(
  parameter int COORD_WIDTH = tpta_pkg::COORD_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic signed [tpta_pkg::COORD_W-1:0] p_x_i,
  input  logic signed [tpta_pkg::COORD_W-1:0] p_y_i,
  input  logic signed [tpta_pkg::COORD_W-1:0] q_x_i,
  input  logic signed [tpta_pkg::COORD_W-1:0] q_y_i,
  output tpta_pkg::vec_t                      vec_o,
  output tpta_pkg::flags_t                    flags_o
);
  import tpta_pkg::*;

  localparam int CIW  = (COORD_WIDTH > COORD_W) ? COORD_W + 1 : COORD_WIDTH;
  localparam int DW   = CIW + 1;
  localparam int MSBW = $clog2(DW);
  localparam int SHW  = $clog2(NORM_TOP + 1);

  logic signed [CIW-1:0] px, py, qx, qy;

  // wider coordinates than the port see the word as unsigned
  if (COORD_WIDTH > COORD_W) begin : g_zext
    assign px = {1'b0, p_x_i};
    assign py = {1'b0, p_y_i};
    assign qx = {1'b0, q_x_i};
    assign qy = {1'b0, q_y_i};
  end else begin : g_sext
    assign px = p_x_i[CIW-1:0];
    assign py = p_y_i[CIW-1:0];
    assign qx = q_x_i[CIW-1:0];
    assign qy = q_y_i[CIW-1:0];
  end

  logic signed [DW-1:0] dx1_q, dy1_q;
  logic signed [DW-1:0] dx2_q, dy2_q;
  logic [DW-1:0]        mag2_q;
  flags_t               fl2_q, fl3_q, fl4_q, fl5_q;
  logic signed [DW-1:0] dx3_q, dy3_q;
  logic [SHW-1:0]       sh3_q;
  logic signed [ACC_W-1:0] x4_q, y4_q;
  vec_t                 vec5_q;

  logic [DW-1:0]  adx, ady;
  flags_t         fl2_d;
  logic [MSBW-1:0] msb;
  vec_t           vec5_d;

  always_ff @(posedge clk_i) begin
    dx1_q <= DW'(qx) - DW'(px);
    dy1_q <= DW'(qy) - DW'(py);
  end

  always_comb begin
    adx           = dx1_q[DW-1] ? DW'(-dx1_q) : DW'(dx1_q);
    ady           = dy1_q[DW-1] ? DW'(-dy1_q) : DW'(dy1_q);
    fl2_d.zero    = (dx1_q == '0) && (dy1_q == '0);
    fl2_d.dx_zero = (dx1_q == '0);
    fl2_d.dy_zero = (dy1_q == '0);
    fl2_d.dx_pos  = !dx1_q[DW-1] && (dx1_q != '0);
    fl2_d.dy_pos  = !dy1_q[DW-1] && (dy1_q != '0);
  end

  always_ff @(posedge clk_i) begin
    dx2_q  <= dx1_q;
    dy2_q  <= dy1_q;
    mag2_q <= adx | ady;
    fl2_q  <= fl2_d;
  end

  // leading one of the larger magnitude
  always_comb begin
    msb = '0;
    for (int b = 0; b < DW; b++) begin
      if (mag2_q[b]) msb = MSBW'(b);
    end
  end

  always_ff @(posedge clk_i) begin
    dx3_q <= dx2_q;
    dy3_q <= dy2_q;
    sh3_q <= SHW'(NORM_TOP) - SHW'(msb);
    fl3_q <= fl2_q;
  end

  always_ff @(posedge clk_i) begin
    x4_q  <= ACC_W'(dx3_q) <<< sh3_q;
    y4_q  <= ACC_W'(dy3_q) <<< sh3_q;
    fl4_q <= fl3_q;
  end

  // left half-plane: negate and preload +/- pi
  always_comb begin
    vec5_d.x   = x4_q;
    vec5_d.y   = y4_q;
    vec5_d.acc = '0;
    if (x4_q[ACC_W-1]) begin
      vec5_d.x   = -x4_q;
      vec5_d.y   = -y4_q;
      vec5_d.acc = y4_q[ACC_W-1] ? -PI_Q60 : PI_Q60;
    end
  end

  always_ff @(posedge clk_i) begin
    vec5_q <= vec5_d;
    fl5_q  <= fl4_q;
  end

  assign vec_o   = vec5_q;
  assign flags_o = fl5_q;

endmodule
`default_nettype wire

@@ hdl/tpta_cordic.sv @@
// Vectoring CORDIC pipeline, one stage per iteration, then clamp and axis cases.
`default_nettype none
module tpta_cordic #(
  parameter int CORDIC_STAGES = tpta_pkg::CORDIC_STAGES_DEF
) (
  input  logic             clk_i,
  input  tpta_pkg::vec_t   vec_i,
  input  tpta_pkg::flags_t flags_i,
  output tpta_pkg::lane_t  lane_o
);
  import tpta_pkg::*;

  logic signed [ACC_W-1:0] x_in [CORDIC_STAGES];
  logic signed [ACC_W-1:0] y_in [CORDIC_STAGES];
  logic signed [ACC_W-1:0] z_in [CORDIC_STAGES];
  flags_t                  f_in [CORDIC_STAGES];
  logic signed [ACC_W-1:0] x_q  [CORDIC_STAGES];
  logic signed [ACC_W-1:0] y_q  [CORDIC_STAGES];
  logic signed [ACC_W-1:0] z_q  [CORDIC_STAGES];
  flags_t                  f_q  [CORDIC_STAGES];

  logic signed [ACC_W-1:0] zl, zc;
  flags_t                  fl;
  lane_t                   lane_d, lane_q;

  always_comb begin
    x_in[0] = vec_i.x;
    y_in[0] = vec_i.y;
    z_in[0] = vec_i.acc;
    f_in[0] = flags_i;
    for (int i = 1; i < CORDIC_STAGES; i++) begin
      x_in[i] = x_q[i-1];
      y_in[i] = y_q[i-1];
      z_in[i] = z_q[i-1];
      f_in[i] = f_q[i-1];
    end
  end

  // rotate toward the x axis, y >= 0 counts as positive
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      f_q[i] <= f_in[i];
      if (!y_in[i][ACC_W-1]) begin
        x_q[i] <= x_in[i] + (y_in[i] >>> i);
        y_q[i] <= y_in[i] - (x_in[i] >>> i);
        z_q[i] <= z_in[i] + ATAN_TAB[i];
      end else begin
        x_q[i] <= x_in[i] - (y_in[i] >>> i);
        y_q[i] <= y_in[i] + (x_in[i] >>> i);
        z_q[i] <= z_in[i] - ATAN_TAB[i];
      end
    end
  end

  always_comb begin
    zl = z_q[CORDIC_STAGES-1];
    fl = f_q[CORDIC_STAGES-1];
    zc = zl;
    if (zl > PI_Q60) zc = PI_Q60;
    if (zl < -PI_Q60) zc = -PI_Q60;
    // axis directions are exact
    if (fl.dy_zero) zc = fl.dx_pos ? '0 : PI_Q60;
    else if (fl.dx_zero) zc = fl.dy_pos ? HALF_PI_Q60 : -HALF_PI_Q60;
    lane_d.z  = zc;
    lane_d.ok = !fl.zero;
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign lane_o = lane_q;

endmodule
`default_nettype wire

@@ hdl/tpta_post.sv @@
// Back end: turn angle wrap and fold, rounding to radians or degrees, output word.
`default_nettype none
module tpta_post (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tpta_pkg::ctrl_t   ctrl_i,
  input  tpta_pkg::lane_t   lane1_i,
  input  tpta_pkg::lane_t   lane2_i,
  input  logic              unit_i,
  output logic              done_o,
  output tpta_pkg::result_t result_o
);
  import tpta_pkg::*;

  ctrl_t c_q  [POST_LAT];
  logic  ok_q [POST_LAT];

  logic signed [ACC_W-1:0] z1_q, z2_q, z3_q;
  logic [ACC_W-1:0]        mag4_q;
  logic                    neg4_q, neg5_q, neg6_q, neg7_q, neg8_q;
  logic [ANGLE_W-1:0]      rad5_q, rad6_q, rad7_q, rad8_q;
  logic [31:0]             q5_q;
  logic [61:0]             prod6_q, prod7_q;
  logic [62:0]             est6_q;
  logic [30:0]             e7_q, d8_q;
  logic [61:0]             ep7_q;
  result_t                 res_q;

  logic signed [ACC_W-1:0] z2_d, z3_d;
  logic [ACC_W-1:0]        rnd_r, rnd_d;
  logic [ACC_W-1:0]        rem;
  logic signed [ANGLE_W:0] sdeg, srad, sres;
  result_t                 res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < POST_LAT; i++) c_q[i] <= '0;
    end else begin
      c_q[0] <= ctrl_i;
      for (int i = 1; i < POST_LAT; i++) c_q[i] <= c_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q[0] <= ctrl_i.kind ? (lane1_i.ok && lane2_i.ok) : lane1_i.ok;
    for (int i = 1; i < POST_LAT; i++) ok_q[i] <= ok_q[i-1];
  end

  always_ff @(posedge clk_i) begin
    z1_q <= ctrl_i.kind ? lane2_i.z - lane1_i.z : lane1_i.z;
  end

  // wrap the turn to [0, 2pi)
  always_comb begin
    z2_d = z1_q;
    if (c_q[0].kind) begin
      if (z1_q[ACC_W-1]) z2_d = z1_q + TWO_PI_Q60;
      else if (z1_q >= TWO_PI_Q60) z2_d = z1_q - TWO_PI_Q60;
    end
  end

  always_ff @(posedge clk_i) begin
    z2_q <= z2_d;
  end

  always_comb begin
    z3_d = z2_q;
    if (c_q[1].kind && (z2_q > PI_Q60)) z3_d = TWO_PI_Q60 - z2_q;
  end

  always_ff @(posedge clk_i) begin
    z3_q <= z3_d;
  end

  always_ff @(posedge clk_i) begin
    neg4_q <= z3_q[ACC_W-1];
    mag4_q <= z3_q[ACC_W-1] ? ACC_W'(-z3_q) : ACC_W'(z3_q);
  end

  // round half away from zero on the magnitude
  always_comb begin
    rnd_r = (mag4_q + (64'd1 << 31)) >> 32;
    rnd_d = (mag4_q + (64'd1 << 29)) >> 30;
  end

  always_ff @(posedge clk_i) begin
    neg5_q <= neg4_q;
    rad5_q <= rnd_r[ANGLE_W-1:0];
    q5_q   <= rnd_d[31:0];
  end

  // quotient estimate by reciprocal, exact or one short
  always_ff @(posedge clk_i) begin
    neg6_q  <= neg5_q;
    rad6_q  <= rad5_q;
    prod6_q <= 62'(q5_q) * 62'(DEG180_Q22[29:0]);
    est6_q  <= 63'(q5_q) * 63'(DEG_RECIP);
  end

  always_ff @(posedge clk_i) begin
    neg7_q  <= neg6_q;
    rad7_q  <= rad6_q;
    prod7_q <= prod6_q;
    e7_q    <= est6_q[62:RECIP_SH];
    ep7_q   <= 62'(est6_q[62:RECIP_SH]) * 62'(PI30);
  end

  always_comb begin
    rem = 64'(prod7_q) + 64'(PI30_HALF) - 64'(ep7_q);
  end

  always_ff @(posedge clk_i) begin
    neg8_q <= neg7_q;
    rad8_q <= rad7_q;
    d8_q   <= (rem >= 64'(PI30)) ? e7_q + 31'd1 : e7_q;
  end

  always_comb begin
    sdeg = neg8_q ? -$signed({2'b00, d8_q}) : $signed({2'b00, d8_q});
    srad = neg8_q ? -$signed({1'b0, rad8_q}) : $signed({1'b0, rad8_q});
    if (c_q[7].kind) begin
      if (sdeg[ANGLE_W]) sdeg = '0;
      if (sdeg > $signed({1'b0, DEG180_Q22})) sdeg = $signed({1'b0, DEG180_Q22});
    end else begin
      if (sdeg <= -$signed({1'b0, DEG180_Q22})) sdeg = 33'sd1 - $signed({1'b0, DEG180_Q22});
      if (sdeg > $signed({1'b0, DEG180_Q22})) sdeg = $signed({1'b0, DEG180_Q22});
    end
    sres            = unit_i ? sdeg : srad;
    res_d.valid_res = ok_q[7];
    res_d.angle     = ok_q[7] ? sres[ANGLE_W-1:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = c_q[POST_LAT-1].valid;
  assign result_o = res_q;

endmodule
`default_nettype wire

@@ hdl/three_point_turn_angle.sv @@
// Top level: direction and turning angle of three points, with APB register.
//
// Usage: pulse start with a word on item_i; busy stays low, so a word is taken
// in every cycle that start is high. kind 0 gives the direction of a->b, kind 1
// the turning angle at b. Each word gives one result word on result_o, marked by
// done_o for a single cycle; results come back in order.
// An accepted word passes the prep registers, the CORDIC stages, the clamp
// register and the back-end registers before its result leaves. Throughput is
// one word per cycle, set by the one-iteration-per-stage CORDIC pipelines, one
// for a->b and one for b->c.
// The receiver cannot hold results off; results simply leave on schedule.
// Register angle_unit at address 0 picks radians Q4.28 (0) or degrees Q10.22 (1);
// write it only while no word is in flight. Reset clears the register and all
// valid bits in the pipeline; words in flight at reset are dropped.
// Coincident points give valid_res = 0 with angle 0.
`default_nettype none
module three_point_turn_angle #(
  parameter int COORD_WIDTH   = tpta_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = tpta_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  tpta_pkg::item_t               item_i,
  output logic                          done_o,
  output tpta_pkg::result_t             result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tpta_pkg::ADDR_W-1:0]   paddr,
  input  logic [tpta_pkg::DATA_W-1:0]   pwdata,
  output logic [tpta_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import tpta_pkg::*;

  localparam int FRONT_LAT = PREP_LAT + CORDIC_STAGES + 1;
  localparam int TOTAL_LAT = FRONT_LAT + POST_LAT;

  logic  angle_unit_q;
  ctrl_t fr_q [FRONT_LAT];
  vec_t  vec1, vec2;
  flags_t fl1, fl2;
  lane_t lane1, lane2;
  logic  accept;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_unit_q <= 1'b0;
    end else if (psel && penable && pwrite && pready
                 && (paddr[ADDR_W-1:2] == REG_ANGLE_UNIT)) begin
      angle_unit_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[ADDR_W-1:2] == REG_ANGLE_UNIT) ? DATA_W'(angle_unit_q) : '0;

  // valid and kind ride alongside the two lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FRONT_LAT; i++) fr_q[i] <= '0;
    end else begin
      fr_q[0].valid <= accept;
      fr_q[0].kind  <= item_i.kind;
      for (int i = 1; i < FRONT_LAT; i++) fr_q[i] <= fr_q[i-1];
    end
  end

  tpta_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep_ab (
    .clk_i   (clk_i),
    .p_x_i   (item_i.ax),
    .p_y_i   (item_i.ay),
    .q_x_i   (item_i.bx),
    .q_y_i   (item_i.by_coord),
    .vec_o   (vec1),
    .flags_o (fl1)
  );

  tpta_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep_bc (
    .clk_i   (clk_i),
    .p_x_i   (item_i.bx),
    .p_y_i   (item_i.by_coord),
    .q_x_i   (item_i.cx),
    .q_y_i   (item_i.cy),
    .vec_o   (vec2),
    .flags_o (fl2)
  );

  tpta_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_ab (
    .clk_i   (clk_i),
    .vec_i   (vec1),
    .flags_i (fl1),
    .lane_o  (lane1)
  );

  tpta_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_bc (
    .clk_i   (clk_i),
    .vec_i   (vec2),
    .flags_i (fl2),
    .lane_o  (lane2)
  );

  tpta_post u_post (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (fr_q[FRONT_LAT-1]),
    .lane1_i  (lane1),
    .lane2_i  (lane2),
    .unit_i   (angle_unit_q),
    .done_o   (done_o),
    .result_o (result_o)
  );

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, TOTAL_LAT))
    else $error("result word without a matching input word");

  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.valid_res) |-> (result_o.angle == '0))
    else $error("coincident points gave a nonzero angle");

  a_deg_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.valid_res && angle_unit_q)
      |-> ((result_o.angle <= $signed(DEG180_Q22))
           && (result_o.angle > -$signed(DEG180_Q22))))
    else $error("degree result outside (-180, 180]");

endmodule
`default_nettype wire

@@ verif/three_point_turn_angle_tb.sv @@
// Self-checking testbench for three_point_turn_angle: directed and random point sets.
`default_nettype none
module three_point_turn_angle_tb;
  import tpta_pkg::*;

  localparam int STAGES     = 28;
  localparam int LATENCY    = 5 + STAGES + 1 + 9;
  localparam int DRAIN      = LATENCY + 20;
  localparam int CYCLE_CAP  = 200000;
  localparam int N_RANDOM   = 1550;
  localparam logic [ADDR_W-1:0] ADDR_ANGLE_UNIT = ADDR_W'(4 * REG_ANGLE_UNIT);
  localparam logic UNIT_RAD = 1'b0;
  localparam logic UNIT_DEG = 1'b1;
  localparam logic KIND_DIR  = 1'b0;
  localparam logic KIND_TURN = 1'b1;

  logic clk_i, rst_ni;
  logic start, busy, done_o;
  item_t item_i;
  result_t result_o;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;

  three_point_turn_angle i_dut (
    .clk_i, .rst_ni, .start, .busy, .item_i, .done_o, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  longint atan_q60 [STAGES];
  longint pi_q60;
  logic   unit_mdl;
  result_t angle_fifo [$];
  int     fails = 0;
  int     cycles = 0;
  logic   busy_smp;
  bit     calm;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) busy_smp <= busy;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && done_o) begin
      if (angle_fifo.size() == 0) begin
        $display("%0t: unexpected word %h", $time, result_o);
        fails++;
      end else begin
        exp_r = angle_fifo.pop_front();
        if (result_o.angle !== exp_r.angle) begin
          $display("%0t: angle exp %h got %h", $time, exp_r.angle, result_o.angle);
          fails++;
        end
        if (result_o.valid_res !== exp_r.valid_res) begin
          $display("%0t: valid_res exp %b got %b", $time, exp_r.valid_res,
                   result_o.valid_res);
          fails++;
        end
      end
    end
  end

  function automatic longint unsigned arctan_sum(longint unsigned p, longint unsigned q);
    longint unsigned s, k;
    bit neg;
    s = 0; k = 0; neg = 0;
    while (p != 0) begin
      s = neg ? s - p / (2 * k + 1) : s + p / (2 * k + 1);
      neg = !neg;
      k++;
      p = (q != 0) ? p / q : 0;
    end
    return s;
  endfunction

  task automatic make_atan_table();
    longint unsigned one, quarter;
    one = 64'd1 << 60;
    quarter = 4 * arctan_sum(one / 5, 25) - arctan_sum(one / 239, 57121);
    pi_q60 = longint'(4 * quarter);
    for (int i = 0; i < STAGES; i++)
      atan_q60[i] = (i == 0) ? longint'(quarter) : longint'(arctan_sum(one >> i, 64'd1 << (2 * i)));
  endtask

  // atan2 in Q60; returns 0 for a zero vector
  function automatic bit heading_q60(longint dx, longint dy, output longint z);
    longint x, y, acc, mx, nx, ny;
    int msb;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    if (dy == 0) begin z = (dx > 0) ? 0 : pi_q60; return 1; end
    if (dx == 0) begin z = (dy > 0) ? (pi_q60 >>> 1) : -(pi_q60 >>> 1); return 1; end
    mx = (dx < 0) ? -dx : dx;
    if (((dy < 0) ? -dy : dy) > mx) mx = (dy < 0) ? -dy : dy;
    msb = 0;
    while (msb < 62 && (mx >>> (msb + 1)) != 0) msb++;
    x = (msb < 56) ? dx <<< (56 - msb) : dx;
    y = (msb < 56) ? dy <<< (56 - msb) : dy;
    acc = 0;
    if (x < 0) begin
      acc = (y >= 0) ? pi_q60 : -pi_q60;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STAGES; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); acc += atan_q60[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); acc -= atan_q60[i];
      end
      x = nx;
      y = ny;
    end
    if (acc > pi_q60) acc = pi_q60;
    if (acc < -pi_q60) acc = -pi_q60;
    z = acc;
    return 1;
  endfunction

  function automatic result_t predict_angle(item_t it);
    longint ax, ay, bx, by, cx, cy, z1, z2, z, res, d180;
    longint unsigned mag, q, pi30;
    bit ok;
    result_t r;
    ax = longint'($signed(it.ax)); ay = longint'($signed(it.ay));
    bx = longint'($signed(it.bx)); by = longint'($signed(it.by_coord));
    cx = longint'($signed(it.cx)); cy = longint'($signed(it.cy));
    d180 = longint'(DEG180_Q22);
    ok = heading_q60(bx - ax, by - ay, z1);
    z = z1;
    if (it.kind == KIND_TURN) begin
      ok = heading_q60(cx - bx, cy - by, z2) && ok;
      z = z2 - z1;
      if (z < 0) z += 2 * pi_q60;
      if (z >= 2 * pi_q60) z -= 2 * pi_q60;
      if (z > pi_q60) z = 2 * pi_q60 - z;
    end
    res = 0;
    if (ok) begin
      mag = longint'((z < 0) ? -z : z);
      if (unit_mdl == UNIT_RAD) begin
        res = longint'((mag + (64'd1 << 31)) >> 32);
      end else begin
        q = (mag + (64'd1 << 29)) >> 30;
        pi30 = (longint'(pi_q60) + (64'd1 << 29)) >> 30;
        res = longint'((q * DEG180_Q22 + pi30 / 2) / pi30);
      end
      if (z < 0) res = -res;
      if (unit_mdl == UNIT_DEG) begin
        if (it.kind == KIND_DIR) begin
          if (res <= -d180) res = -d180 + 1;
        end else if (res < 0) res = 0;
        if (res > d180) res = d180;
      end
    end
    r.angle = ok ? res[31:0] : '0;
    r.valid_res = ok;
    return r;
  endfunction

  task automatic reg_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_ANGLE_UNIT) unit_mdl = data[0];
  endtask

  // sends one word; start is left high for the caller
  task automatic send_word(item_t it);
    result_t r;
    if (!calm && $urandom_range(0, 99) < 4) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    r = predict_angle(it);
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy_smp);
    angle_fifo.push_back(r);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (angle_fifo.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h1;
      default: return $urandom;
    endcase
  endfunction

  function automatic item_t mk(logic k, int ax, int ay, int bx, int by, int cx, int cy);
    item_t it;
    it.kind = k; it.ax = ax; it.ay = ay; it.bx = bx; it.by_coord = by; it.cx = cx; it.cy = cy;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int sel;
    it = $urandom_range(0, 1) ? {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                                 1'b1} : '0;
    it.kind = $urandom_range(0, 1);
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      it.ax = $signed($urandom) >>> $urandom_range(8, 30);
      it.ay = $signed($urandom) >>> $urandom_range(8, 30);
      it.bx = $signed($urandom) >>> $urandom_range(8, 30);
      it.by_coord = $signed($urandom) >>> $urandom_range(8, 30);
      it.cx = $signed($urandom) >>> $urandom_range(8, 30);
      it.cy = $signed($urandom) >>> $urandom_range(8, 30);
    end else if (sel < 6) begin
      it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b0};
      it.kind = $urandom_range(0, 1);
    end else if (sel == 6) begin
      it.bx = it.ax; it.by_coord = it.ay;
    end else if (sel == 7) begin
      it.cx = it.bx; it.cy = it.by_coord;
    end else if (sel == 8) begin
      if ($urandom_range(0, 1)) it.bx = it.ax; else it.by_coord = it.ay;
      if ($urandom_range(0, 1)) it.cx = it.bx; else it.cy = it.by_coord;
    end else begin
      it.ax = pick_coord(); it.ay = pick_coord(); it.bx = pick_coord();
      it.by_coord = pick_coord(); it.cx = pick_coord(); it.cy = pick_coord();
    end
    return it;
  endfunction

  task automatic test_directed(logic unit);
    reg_write(ADDR_ANGLE_UNIT, {31'h0, unit});
    calm = 1;
    send_word(mk(KIND_DIR, 0, 0, 65536, 0, 0, 0));
    send_word(mk(KIND_DIR, 0, 0, -65536, 0, 0, 0));
    send_word(mk(KIND_DIR, 0, 0, 0, 65536, 0, 0));
    send_word(mk(KIND_DIR, 0, 0, 0, -65536, 0, 0));
    send_word(mk(KIND_DIR, 5, 5, 5, 5, 9, 9));
    send_word(mk(KIND_TURN, 1, 1, 1, 1, 7, 3));
    send_word(mk(KIND_TURN, 0, 0, 4, 4, 4, 4));
    send_word(mk(KIND_DIR, 0, 0, 1, 1, 0, 0));
    send_word(mk(KIND_DIR, 0, 0, -1, -1, 0, 0));
    // just below the negative x axis: near -180
    send_word(mk(KIND_DIR, 0, 0, 32'h8000_0000, -1, 0, 0));
    send_word(mk(KIND_DIR, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 0, 0));
    send_word(mk(KIND_DIR, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 0, 0));
    send_word(mk(KIND_TURN, 0, 0, 65536, 0, 131072, 0));
    send_word(mk(KIND_TURN, 0, 0, 65536, 0, 0, 0));
    send_word(mk(KIND_TURN, 0, 0, 65536, 0, 65536, 65536));
    send_word(mk(KIND_TURN, 0, 0, 65536, 0, 65536, -65536));
    send_word(mk(KIND_TURN, 0, 0, 65536, 0, 0, -1));
    send_word(mk(KIND_TURN, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h8000_0000, 32'h8000_0000));
    send_word(mk(KIND_TURN, 0, 0, -65536, 1, -131072, 0));
    send_word('1);
    send_word('0);
    calm = 0;
    settle();
  endtask

  task automatic test_random(int n);
    int quiet_from;
    quiet_from = n / 3;
    for (int i = 0; i < n; i++) begin
      calm = (i >= quiet_from && i < quiet_from + n / 5);
      send_word(random_item());
    end
    calm = 0;
    settle();
  endtask

  initial begin
    calm = 0;
    unit_mdl = UNIT_RAD;
    make_atan_table();
    rst_ni <= 1'b0; start <= 1'b0; item_i <= '0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed(UNIT_RAD);
    test_directed(UNIT_DEG);
    reg_write(ADDR_ANGLE_UNIT, 32'hffff_fffe);
    test_random(N_RANDOM / 4);
    reg_write(ADDR_ANGLE_UNIT, 32'h0000_0001);
    test_random(N_RANDOM / 4);
    reg_write(ADDR_ANGLE_UNIT, 32'h0000_0000);
    test_random(N_RANDOM / 4);
    reg_write(ADDR_ANGLE_UNIT, 32'hffff_ffff);
    test_random(N_RANDOM / 4);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
hdl/tpta_pkg.sv
hdl/tpta_prep.sv
hdl/tpta_cordic.sv
hdl/tpta_post.sv
hdl/three_point_turn_angle.sv
verif/three_point_turn_angle_tb.sv
